@@ rtl/core/depth_tested_pixel_store_core_assert.svh @@
// assertion macros used by the checker file dtps_checker
`ifndef DEPTH_TESTED_PIXEL_STORE_CORE_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_STORE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DTPS_ASSERT_IMPLY(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtps assertion failed");

// condition holds at every clock edge out of reset
`define DTPS_ASSERT_ALWAYS(label, ck, rst_n, cond) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (cond)) \
		else $error("dtps assertion failed");

`endif

@@ rtl/core/dtps_pkg.sv @@
// ----------------------------------------------------------------------------
// dtps_pkg
// Types and constants shared by the depth tested pixel store.
// ----------------------------------------------------------------------------
`default_nettype none

package dtps_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_DEPTH_BITS = 24;

	localparam int CFG_DATA_W   = 9;
	localparam int CFG_INDEX_W  = 2;
	localparam int COORD_W      = 8;
	localparam int COLOR_W      = 32;
	localparam int FRAG_DEPTH_W = 24;
	localparam int REQ_W        = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 9'd256;

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	typedef enum logic [2:0] {
		ST_WRITTEN = 3'd0,
		ST_FAILED  = 3'd1,
		ST_RANGE   = 3'd2,
		ST_CLEARED = 3'd3,
		ST_READ    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_RANGE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BK_INIT   = 2'd0,
		BK_IDLE   = 2'd1,
		BK_LOOKUP = 2'd2,
		BK_CLEAR  = 2'd3
	} back_state_t;

	typedef struct packed {
		logic                    done;
		status_t                 status;
		logic [COLOR_W-1:0]      color;
		logic [FRAG_DEPTH_W-1:0] depth;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/dtps_ram.sv @@
// ----------------------------------------------------------------------------
// dtps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/dtps_fifo.sv @@
// ----------------------------------------------------------------------------
// dtps_fifo
// Two entry queue between the request front end and the store back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head,
	output logic              full,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dtps_front.sv @@
// ----------------------------------------------------------------------------
// dtps_front
// Holds the size registers, accepts requests and classifies them into
// store operations with a resolved pixel address.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_front import dtps_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS,
	parameter int ADDR_W     = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [COORD_W-1:0]      pos_x,
	input  logic [COORD_W-1:0]      pos_y,
	input  logic [COLOR_W-1:0]      frag_color,
	input  logic [FRAG_DEPTH_W-1:0] frag_depth,
	input  logic                    q_full,
	input  logic                    back_init,
	output logic                    push,
	output kind_t                   push_kind,
	output logic [ADDR_W-1:0]       push_addr,
	output logic [COLOR_W-1:0]      push_color,
	output logic [DEPTH_BITS-1:0]   push_depth
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = COORD_W + WW;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [WW-1:0]         w_eff;
	logic [HW-1:0]         h_eff;
	logic                  in_range;
	logic [RW-1:0]         row_base;
	logic [RW-1:0]         pix_sum;
	logic [WW+HW-1:0]      area;
	logic [ADDR_W-1:0]     clear_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_SIZE_RESET;
			height_q <= CFG_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign in_range   = (32'(pos_x) < 32'(w_eff)) && (32'(pos_y) < 32'(h_eff));
	assign row_base   = RW'(pos_y) * RW'(w_eff);
	assign pix_sum    = row_base + RW'(pos_x);
	assign area       = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);
	assign clear_last = ADDR_W'(area - (WW+HW)'(1));

	always_comb begin
		case (req_type)
			REQ_WRITE: push_kind = in_range ? KIND_WRITE : KIND_RANGE;
			REQ_READ:  push_kind = in_range ? KIND_READ : KIND_RANGE;
			REQ_CLEAR: push_kind = KIND_CLEAR;
			default:   push_kind = KIND_RANGE;
		endcase
	end

	// a clear carries its last address in the address field
	assign push_addr  = (push_kind == KIND_CLEAR) ? clear_last : ADDR_W'(pix_sum);
	assign push_color = frag_color;
	assign push_depth = DEPTH_BITS'(frag_depth);

	assign busy = q_full || back_init;
	assign push = start && !busy;

endmodule

`default_nettype wire

@@ rtl/core/dtps_back.sv @@
// ----------------------------------------------------------------------------
// dtps_back
// Carries out queued operations on the colour and depth stores: depth
// test and store, pixel read, clear sweep, and the sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_back import dtps_pkg::*; #(
	parameter int DEPTH_BITS  = DEF_DEPTH_BITS,
	parameter int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
	parameter int ADDR_W      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  kind_t                 q_kind,
	input  logic [ADDR_W-1:0]     q_addr,
	input  logic [COLOR_W-1:0]    q_color,
	input  logic [DEPTH_BITS-1:0] q_depth,
	output logic                  q_pop,
	output logic                  initializing,
	output result_t               result
);

	localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_DEPTH - 1);

	back_state_t           state_q;
	back_state_t           state_d;
	logic [ADDR_W-1:0]     sweep_q;
	kind_t                 cur_kind_q;
	logic [ADDR_W-1:0]     cur_addr_q;
	logic [COLOR_W-1:0]    cur_color_q;
	logic [DEPTH_BITS-1:0] cur_depth_q;
	result_t               res_q;
	result_t               res_d;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COLOR_W-1:0]    color_wdata;
	logic [DEPTH_BITS-1:0] depth_wdata;
	logic [COLOR_W-1:0]    color_rdata;
	logic [DEPTH_BITS-1:0] depth_rdata;

	dtps_ram #(
		.DATA_W (COLOR_W),
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_color_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (color_wdata),
		.raddr (q_addr),
		.rdata (color_rdata)
	);

	dtps_ram #(
		.DATA_W (DEPTH_BITS),
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_depth_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (depth_wdata),
		.raddr (q_addr),
		.rdata (depth_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_INIT: begin
				if (sweep_q == STORE_LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					case (q_kind)
						KIND_WRITE: state_d = BK_LOOKUP;
						KIND_READ:  state_d = BK_LOOKUP;
						KIND_CLEAR: state_d = BK_CLEAR;
						default:    state_d = BK_IDLE;
					endcase
				end
			end
			BK_LOOKUP: state_d = BK_IDLE;
			BK_CLEAR: begin
				if (sweep_q == cur_addr_q) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = cur_addr_q;
		color_wdata   = cur_color_q;
		depth_wdata   = cur_depth_q;
		res_d.done    = 1'b0;
		res_d.status  = ST_RANGE;
		res_d.color   = '0;
		res_d.depth   = '0;
		case (state_q)
			BK_INIT: begin
				ram_we      = 1'b1;
				ram_waddr   = sweep_q;
				color_wdata = '0;
				depth_wdata = '0;
			end
			BK_IDLE: begin
				// read address is the queue head, data lands in the lookup cycle
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_kind == KIND_RANGE) begin
						res_d.done = 1'b1;
					end
				end
			end
			BK_LOOKUP: begin
				res_d.done = 1'b1;
				if (cur_kind_q == KIND_WRITE) begin
					if (cur_depth_q > depth_rdata) begin
						ram_we       = 1'b1;
						res_d.status = ST_WRITTEN;
					end else begin
						res_d.status = ST_FAILED;
					end
				end else begin
					res_d.status = ST_READ;
					res_d.color  = color_rdata;
					res_d.depth  = FRAG_DEPTH_W'(depth_rdata);
				end
			end
			BK_CLEAR: begin
				ram_we      = 1'b1;
				ram_waddr   = sweep_q;
				color_wdata = '0;
				depth_wdata = '0;
				if (sweep_q == cur_addr_q) begin
					res_d.done   = 1'b1;
					res_d.status = ST_CLEARED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			sweep_q <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (state_q == BK_IDLE) begin
				sweep_q <= '0;
			end else if (state_q == BK_INIT || state_q == BK_CLEAR) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_kind_q  <= q_kind;
			cur_addr_q  <= q_addr;
			cur_color_q <= q_color;
			cur_depth_q <= q_depth;
		end
	end

	assign initializing = (state_q == BK_INIT);
	assign result       = res_q;

endmodule

`default_nettype wire

@@ rtl/core/depth_tested_pixel_store_core.sv @@
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_core
// Colour and depth frame store with a greater-wins depth test.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one entry a cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries (65536 by default) with busy high. A request
// is taken when start is high and busy low; requests wait in a two entry queue
// and busy also rises when that queue is full. The store back end handles one
// request at a time: a fragment write or a pixel read does a RAM lookup, then
// test and store; an out of range request is answered from idle; a clear sweeps
// width*height entries, one entry a cycle through the single RAM write port.
// Each request gives one result, shown on done for a single cycle in the cycle
// after the back end finishes; the receiver cannot stall it, so sample it then.
// Size registers are written through cfg_valid / cfg_ready (always ready); the
// user must write them only while no request is outstanding, unchecked here.
`default_nettype none

module depth_tested_pixel_store_core import dtps_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [COORD_W-1:0]      pos_x,
	input  logic [COORD_W-1:0]      pos_y,
	input  logic [COLOR_W-1:0]      frag_color,
	input  logic [FRAG_DEPTH_W-1:0] frag_depth,
	output logic                    done,
	output logic [2:0]              status,
	output logic [COLOR_W-1:0]      read_color,
	output logic [FRAG_DEPTH_W-1:0] read_depth
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int COL_LO      = DEPTH_BITS;
	localparam int ADDR_LO     = COL_LO + COLOR_W;
	localparam int KIND_LO     = ADDR_LO + ADDR_W;
	localparam int ENTRY_W     = KIND_LO + 2;

	logic                  push;
	kind_t                 push_kind;
	logic [ADDR_W-1:0]     push_addr;
	logic [COLOR_W-1:0]    push_color;
	logic [DEPTH_BITS-1:0] push_depth;
	logic [ENTRY_W-1:0]    push_data;
	logic [ENTRY_W-1:0]    head;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	logic                  back_init;
	result_t               result;

	dtps_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DEPTH_BITS (DEPTH_BITS),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.frag_color (frag_color),
		.frag_depth (frag_depth),
		.q_full     (q_full),
		.back_init  (back_init),
		.push       (push),
		.push_kind  (push_kind),
		.push_addr  (push_addr),
		.push_color (push_color),
		.push_depth (push_depth)
	);

	assign push_data = {push_kind, push_addr, push_color, push_depth};

	dtps_fifo #(
		.DATA_W (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	dtps_back #(
		.DEPTH_BITS  (DEPTH_BITS),
		.STORE_DEPTH (STORE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_kind       (kind_t'(head[KIND_LO +: 2])),
		.q_addr       (head[ADDR_LO +: ADDR_W]),
		.q_color      (head[COL_LO +: COLOR_W]),
		.q_depth      (head[0 +: DEPTH_BITS]),
		.q_pop        (q_pop),
		.initializing (back_init),
		.result       (result)
	);

	assign done       = result.done;
	assign status     = result.status;
	assign read_color = result.color;
	assign read_depth = result.depth;

endmodule

`default_nettype wire

@@ rtl/core/dtps_checker.sv @@
// ----------------------------------------------------------------------------
// dtps_checker
// Port level checks on the depth tested pixel store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_tested_pixel_store_core_assert.svh"

module dtps_checker import dtps_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [2:0]              status,
	input logic [COLOR_W-1:0]      read_color,
	input logic [FRAG_DEPTH_W-1:0] read_depth
);

	// queue, back end and result register hold at most four words
	localparam logic [2:0] MAX_PENDING = 3'd4;

	logic [2:0] pending_q;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (accept && !done) begin
			pending_q <= pending_q + 3'd1;
		end else if (done && !accept) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`DTPS_ASSERT_IMPLY(a_status_code, clk, arst_n, done, (status == ST_WRITTEN || status == ST_FAILED || status == ST_RANGE || status == ST_CLEARED || status == ST_READ))
	`DTPS_ASSERT_IMPLY(a_data_zero, clk, arst_n, (done && status != ST_READ), (read_color == '0 && read_depth == '0))
	`DTPS_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, (pending_q != 3'd0))
	`DTPS_ASSERT_ALWAYS(a_pending_bound, clk, arst_n, (pending_q <= MAX_PENDING))

endmodule

bind depth_tested_pixel_store_core dtps_checker u_dtps_checker (.*);

`default_nettype wire

@@ tb/sv/depth_tested_pixel_store_core_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_core_checker
// Watches the request, size register and result ports of the pixel store.
// Keeps its own colour and depth frame, models every accepted request, with the
// greater-wins depth test on writes, and checks each result word against it.
// ----------------------------------------------------------------------------

module depth_tested_pixel_store_core_checker import dtps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    start,
	input  logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [COORD_W-1:0]      pos_x,
	input  logic [COORD_W-1:0]      pos_y,
	input  logic [COLOR_W-1:0]      frag_color,
	input  logic [FRAG_DEPTH_W-1:0] frag_depth,
	input  logic                    done,
	input  logic [2:0]              status,
	input  logic [COLOR_W-1:0]      read_color,
	input  logic [FRAG_DEPTH_W-1:0] read_depth,
	output int                      mismatch_count,
	output int                      outstanding
);

	localparam int STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	typedef struct packed {
		status_t                 status;
		logic [COLOR_W-1:0]      color;
		logic [FRAG_DEPTH_W-1:0] depth;
	} pixel_result_t;

	logic [COLOR_W-1:0]      color_mem [STORE_WORDS];
	logic [FRAG_DEPTH_W-1:0] depth_mem [STORE_WORDS];
	logic [CFG_DATA_W-1:0]   width_reg;
	logic [CFG_DATA_W-1:0]   height_reg;
	pixel_result_t           pixel_results_q [$];

	// zero acts as one, anything past the frame acts as the frame size
	function automatic int unsigned size_in_effect(input logic [CFG_DATA_W-1:0] v,
			input int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return 32'(v);
	endfunction

	function automatic pixel_result_t z_test_and_store(input logic [REQ_W-1:0] kind,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COLOR_W-1:0] col, input logic [FRAG_DEPTH_W-1:0] dep);
		pixel_result_t r;
		int unsigned w;
		int unsigned h;
		int unsigned addr;
		int unsigned i;
		r.status = ST_RANGE;
		r.color  = '0;
		r.depth  = '0;
		w = size_in_effect(width_reg, DEF_MAX_WIDTH);
		h = size_in_effect(height_reg, DEF_MAX_HEIGHT);
		case (kind)
			REQ_CLEAR: begin
				// only the active window is swept, the rest keeps its contents
				for (i = 0; i < w * h; i++) begin
					color_mem[i] = '0;
					depth_mem[i] = '0;
				end
				r.status = ST_CLEARED;
			end
			REQ_WRITE, REQ_READ: begin
				if (x < w && y < h) begin
					addr = x + y * w;
					if (kind == REQ_READ) begin
						r.color  = color_mem[addr];
						r.depth  = depth_mem[addr];
						r.status = ST_READ;
					end else if (dep > depth_mem[addr]) begin
						color_mem[addr] = col;
						depth_mem[addr] = dep;
						r.status = ST_WRITTEN;
					end else begin
						r.status = ST_FAILED;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %h got %h", $time, field, want_v, got_v);
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < STORE_WORDS; i++) begin
				color_mem[i] = '0;
				depth_mem[i] = '0;
			end
			width_reg = CFG_SIZE_RESET;
			height_reg = CFG_SIZE_RESET;
			pixel_results_q.delete();
			mismatch_count = 0;
		end else begin
			// retire the older word first, a new request can never be answered yet
			if (done === 1'b1) begin
				if (pixel_results_q.size() == 0) begin
					mismatch_count++;
					$display({"%0t: result with none expected, expected nothing",
						" got status %0d color %h depth %h"},
						$time, status, read_color, read_depth);
				end else begin
					want = pixel_results_q.pop_front();
					if (status !== want.status)
						flag_mismatch("status", 32'(want.status), 32'(status));
					if (read_color !== want.color)
						flag_mismatch("read_color", want.color, read_color);
					if (read_depth !== want.depth)
						flag_mismatch("read_depth", 32'(want.depth), 32'(read_depth));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				pixel_results_q.push_back(z_test_and_store(req_type, pos_x, pos_y,
					frag_color, frag_depth));
		end
		outstanding = pixel_results_q.size();
	end

endmodule

@@ tb/sv/depth_tested_pixel_store_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_core_tb
// Drives fragment writes, reads, clears and bad requests into the pixel store
// under many active sizes, with random gaps, and reports the verdict from the
// checker that runs beside the block.
// ----------------------------------------------------------------------------

module depth_tested_pixel_store_core_tb;
	import dtps_pkg::*;

	localparam int ITEM_COUNT     = 1350;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int CLEAR_AREA_MAX = 4096;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [REQ_W-1:0]       REQ_UNDEFINED = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [REQ_W-1:0]        req_type = '0;
	logic [COORD_W-1:0]      pos_x = '0;
	logic [COORD_W-1:0]      pos_y = '0;
	logic [COLOR_W-1:0]      frag_color = '0;
	logic [FRAG_DEPTH_W-1:0] frag_depth = '0;
	logic                    done;
	logic [2:0]              status;
	logic [COLOR_W-1:0]      read_color;
	logic [FRAG_DEPTH_W-1:0] read_depth;

	int fail_count;
	int pending;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit no_gaps = 1'b0;
	logic [CFG_DATA_W-1:0] width_now = CFG_SIZE_RESET;
	logic [CFG_DATA_W-1:0] height_now = CFG_SIZE_RESET;
	int unsigned eff_w = DEF_MAX_WIDTH;
	int unsigned eff_h = DEF_MAX_HEIGHT;

	always #5 clk = ~clk;

	depth_tested_pixel_store_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.frag_color (frag_color),
		.frag_depth (frag_depth),
		.done       (done),
		.status     (status),
		.read_color (read_color),
		.read_depth (read_depth)
	);

	depth_tested_pixel_store_core_checker pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.frag_color     (frag_color),
		.frag_depth     (frag_depth),
		.done           (done),
		.status         (status),
		.read_color     (read_color),
		.read_depth     (read_depth),
		.mismatch_count (fail_count),
		.outstanding    (pending)
	);

	// any word moving on any channel resets the count
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("depth_tested_pixel_store_core verification failed");
		$finish;
	end

	function automatic int gap_length();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(19, 0);
		if (r < 10)
			return 0;
		if (r < 17)
			return $urandom_range(3, 1);
		if (r < 19)
			return $urandom_range(8, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic issue(input logic [REQ_W-1:0] kind, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COLOR_W-1:0] col,
			input logic [FRAG_DEPTH_W-1:0] dep);
		int gap;
		start <= 1'b1;
		req_type <= kind;
		pos_x <= x;
		pos_y <= y;
		frag_color <= col;
		frag_depth <= dep;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		gap = gap_length();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// size registers only change with nothing in flight
	task automatic set_sizes(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
			input bit write_w, input bit write_h, input bit spare);
		logic [CFG_INDEX_W-1:0] idx_q [$];
		logic [CFG_DATA_W-1:0]  val_q [$];
		drain();
		if (write_w) begin
			idx_q.push_back(REG_WIDTH);
			val_q.push_back(wv);
			width_now = wv;
		end
		if (write_h) begin
			if ($urandom_range(1, 0)) begin
				idx_q.push_front(REG_HEIGHT);
				val_q.push_front(hv);
			end else begin
				idx_q.push_back(REG_HEIGHT);
				val_q.push_back(hv);
			end
			height_now = hv;
		end
		if (spare) begin
			idx_q.push_front($urandom_range(1, 0) ? REG_SPARE_2 : REG_SPARE_3);
			val_q.push_front(CFG_DATA_W'($urandom));
		end
		foreach (idx_q[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_q[i];
			cfg_data <= val_q[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		eff_w = (width_now == '0) ? 1 : ((width_now > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_now);
		eff_h = (height_now == '0) ? 1 :
			((height_now > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_now);
	endtask

	function automatic logic [CFG_DATA_W-1:0] extreme_size();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_SIZE_RESET;
			3: return '1;
			4: return CFG_DATA_W'($urandom_range(510, 257));
			default: return CFG_DATA_W'($urandom_range(255, 2));
		endcase
	endfunction

	task automatic random_sizes();
		logic [CFG_DATA_W-1:0] wv;
		logic [CFG_DATA_W-1:0] hv;
		int pick;
		case ($urandom_range(9, 0))
			0, 1, 2, 3, 4, 5: begin
				wv = CFG_DATA_W'($urandom_range(16, 1));
				hv = CFG_DATA_W'($urandom_range(16, 1));
			end
			6: begin
				wv = CFG_DATA_W'($urandom_range(256, 1));
				hv = CFG_DATA_W'($urandom_range(8, 1));
			end
			7: begin
				wv = CFG_DATA_W'($urandom_range(8, 1));
				hv = CFG_DATA_W'($urandom_range(256, 1));
			end
			8: begin
				wv = extreme_size();
				hv = extreme_size();
			end
			default: begin
				wv = CFG_DATA_W'($urandom);
				hv = CFG_DATA_W'($urandom);
			end
		endcase
		pick = $urandom_range(3, 0);
		set_sizes(wv, hv, pick != 1, pick != 0, $urandom_range(3, 0) == 0);
	endtask

	task automatic random_request();
		int r;
		logic [REQ_W-1:0]        kind;
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic [COLOR_W-1:0]      col;
		logic [FRAG_DEPTH_W-1:0] dep;
		r = $urandom_range(99, 0);
		x = COORD_W'($urandom_range(eff_w - 1, 0));
		y = COORD_W'($urandom_range(eff_h - 1, 0));
		col = $urandom;
		// shallow depths make ties and losing fragments common
		dep = $urandom_range(1, 0) ? FRAG_DEPTH_W'($urandom) :
			FRAG_DEPTH_W'($urandom_range(15, 0));
		if (r < 45) begin
			kind = REQ_WRITE;
		end else if (r < 78) begin
			kind = REQ_READ;
		end else if (r < 84) begin
			kind = (eff_w * eff_h <= CLEAR_AREA_MAX) ? REQ_CLEAR : REQ_READ;
		end else if (r < 88) begin
			kind = REQ_UNDEFINED;
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end else begin
			// coordinates over the whole port range, mostly outside the window
			kind = $urandom_range(1, 0) ? REQ_WRITE : REQ_READ;
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
		issue(kind, x, y, col, dep);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// full frame after reset
		issue(REQ_READ, 8'd0, 8'd0, 32'h0, 24'h0);
		issue(REQ_WRITE, 8'd0, 8'd0, 32'h0, 24'h0);
		issue(REQ_WRITE, 8'd0, 8'd0, 32'h12345678, 24'h000001);
		issue(REQ_WRITE, 8'd0, 8'd0, 32'hffffffff, 24'h000001);
		issue(REQ_WRITE, 8'd0, 8'd0, 32'hffffffff, 24'hffffff);
		issue(REQ_READ, 8'd0, 8'd0, 32'h0, 24'h0);
		issue(REQ_WRITE, 8'd255, 8'd255, 32'ha5a5a5a5, 24'hffffff);
		issue(REQ_READ, 8'd255, 8'd255, 32'h0, 24'h0);
		issue(REQ_WRITE, 8'd255, 8'd0, 32'h5a5a5a5a, 24'h800000);
		issue(REQ_UNDEFINED, 8'd17, 8'd17, 32'hdeadbeef, 24'h123456);

		// 4 x 3 window: edges, then a clear of the window only
		set_sizes(9'd4, 9'd3, 1'b1, 1'b1, 1'b0);
		issue(REQ_WRITE, 8'd4, 8'd0, 32'h11111111, 24'hffffff);
		issue(REQ_READ, 8'd0, 8'd3, 32'h0, 24'h0);
		issue(REQ_WRITE, 8'd3, 8'd2, 32'h0, 24'h000007);
		issue(REQ_READ, 8'd3, 8'd2, 32'h0, 24'h0);
		issue(REQ_CLEAR, 8'd0, 8'd0, 32'h0, 24'h0);
		issue(REQ_READ, 8'd3, 8'd2, 32'h0, 24'h0);

		// back to the full frame, pixels outside the window survived
		set_sizes(CFG_SIZE_RESET, CFG_SIZE_RESET, 1'b1, 1'b1, 1'b1);
		issue(REQ_READ, 8'd255, 8'd255, 32'h0, 24'h0);
		issue(REQ_READ, 8'd255, 8'd0, 32'h0, 24'h0);

		// zero sizes act as one pixel
		set_sizes('0, '0, 1'b1, 1'b1, 1'b1);
		issue(REQ_WRITE, 8'd0, 8'd0, 32'hcafef00d, 24'h000003);
		issue(REQ_WRITE, 8'd1, 8'd0, 32'hcafef00d, 24'hffffff);
		issue(REQ_CLEAR, 8'd0, 8'd0, 32'h0, 24'h0);

		// oversized values act as the full frame
		set_sizes('1, 9'd300, 1'b1, 1'b1, 1'b0);
		issue(REQ_READ, 8'd255, 8'd255, 32'h0, 24'h0);
		issue(REQ_CLEAR, 8'd0, 8'd0, 32'h0, 24'h0);
		issue(REQ_READ, 8'd255, 8'd255, 32'h0, 24'h0);
		issue(REQ_READ, 8'd0, 8'd0, 32'h0, 24'h0);

		while (items_sent < ITEM_COUNT) begin
			random_sizes();
			no_gaps = ($urandom_range(4, 0) == 0);
			repeat ($urandom_range(80, 20)) random_request();
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("depth_tested_pixel_store_core verification clean");
		else
			$display("depth_tested_pixel_store_core verification failed");
		$finish;
	end

endmodule
